/* rtl/sorted_list_insert_remove_top_defines.svh */
// assertion macros for the sorted list block
// used by the top level only, no other dependencies
`ifndef SORTED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sli_pkg.sv */
// types, codes and sizes shared by the sorted list cells and top level
// no dependencies
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [COUNT_W-1:0]       count_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// per-cell control for one cycle
	typedef struct packed {
		logic ins;       // insert transaction commits this cycle
		logic rem;       // remove transaction commits this cycle
		logic occupied;  // cell index below held count
		logic at_tail;   // cell index equals held count
		logic past_pos;  // cell index at or above remove position
	} cell_ctl_t;

endpackage

/* rtl/sorted_list_insert_remove_top.sv */
// sorted list insert/remove: result valid is registered and rises in the cycle after the input transaction
// is accepted; throughput one transaction per cycle while out_ready drains each result; every cell compares
// and shifts in parallel so the chain of cells finishes an insert or remove in the cycle it is accepted
// reset (arst_n low, asynchronous) empties the list and drops any pending result
// entry storage has no reset; slots at or above the count are never shown
// depends on sli_pkg, sli_cell and sorted_list_insert_remove_top_defines.svh
`include "sorted_list_insert_remove_top_defines.svh"

module sorted_list_insert_remove_top
	import sli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input transactions
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic signed [31:0]  value,
	input  logic [POS_W-1:0]    position,
	// result transactions
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [COUNT_W-1:0]  entry_count,
	output logic signed [31:0]  smallest,
	output logic                smallest_valid
);

	// held count and result register
	count_t  count_q;
	logic    out_valid_q;
	status_t status_q;
	count_t  entry_count_q;
	data_t   smallest_q;
	logic    smallest_valid_q;

	logic    in_accept;
	status_t status_d;
	count_t  count_d;
	logic    do_ins;
	logic    do_rem;
	count_t  pos_ext;

	// chain wiring
	data_t     cell_value [CAPACITY];
	data_t     cell_next  [CAPACITY];
	logic      cell_gt    [CAPACITY];
	cell_ctl_t cell_ctl   [CAPACITY];

	// a new transaction enters whenever the result slot is free or being drained
	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	assign pos_ext = count_t'(position);

	// status decode; empty is checked before the position
	always_comb begin
		status_d = ST_DONE;
		if (op_t'(command) == OP_INSERT) begin
			if (count_q >= count_t'(CAPACITY)) begin
				status_d = ST_FULL;
			end
		end else begin
			priority if (count_q == '0) begin
				status_d = ST_EMPTY;
			end else if (pos_ext >= count_q) begin
				status_d = ST_BADPOS;
			end else begin
				status_d = ST_DONE;
			end
		end
	end

	// list only changes on a successful transaction
	assign do_ins = in_accept && (op_t'(command) == OP_INSERT) && (status_d == ST_DONE);
	assign do_rem = in_accept && (op_t'(command) == OP_REMOVE) && (status_d == ST_DONE);

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + count_t'(1);
		end else if (do_rem) begin
			count_d = count_q - count_t'(1);
		end
	end

	// row of cells, each talks to its left and right neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_ctl[i].ins      = do_ins;
		assign cell_ctl[i].rem      = do_rem;
		assign cell_ctl[i].occupied = count_t'(i) < count_q;
		assign cell_ctl[i].at_tail  = count_t'(i) == count_q;
		assign cell_ctl[i].past_pos = count_t'(i) >= pos_ext;

		data_t left_value;
		logic  left_gt;
		data_t right_value;

		if (i == 0) begin : g_head
			// nothing to the left of slot 0
			assign left_value = '0;
			assign left_gt    = 1'b0;
		end else begin : g_mid
			assign left_value = cell_value[i-1];
			assign left_gt    = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			// last slot drops out of range on remove, contents don't matter
			assign right_value = cell_value[i];
		end else begin : g_body
			assign right_value = cell_value[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[i]),
			.ins_value   (value),
			.left_value  (left_value),
			.left_gt     (left_gt),
			.right_value (right_value),
			.value       (cell_value[i]),
			.gt          (cell_gt[i]),
			.next_value  (cell_next[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, smallest comes from slot 0 after the update
	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_q         <= status_d;
			entry_count_q    <= count_d;
			smallest_valid_q <= (count_d != '0);
			smallest_q       <= (count_d != '0) ? cell_next[0] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_count    = entry_count_q;
	assign smallest       = smallest_q;
	assign smallest_valid = smallest_valid_q;

	// checks
	`SLI_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= count_t'(CAPACITY), "count beyond capacity")
	`SLI_ASSERT_NEXT(a_insert_grows, clk, arst_n, do_ins, count_q == $past(count_q) + count_t'(1), "insert did not grow count")
	`SLI_ASSERT_NOW(a_valid_match, clk, arst_n, out_valid_q, smallest_valid_q == (entry_count_q != '0), "smallest_valid disagrees with count")
	`SLI_ASSERT_NOW(a_full_count, clk, arst_n, out_valid_q && (status_q == ST_FULL), entry_count_q == count_t'(CAPACITY), "full status below capacity")

endmodule

/* rtl/sli_cell.sv */
// one slot of the sorted list: holds an entry, compares it, shifts with neighbors
// depends on sli_pkg
module sli_cell
	import sli_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  data_t     ins_value,
	input  data_t     left_value,
	input  logic      left_gt,
	input  data_t     right_value,
	output data_t     value,
	output logic      gt,
	output data_t     next_value
);

	data_t value_q;

	// occupied entries strictly greater than the new value move up
	assign gt = ctl.occupied && (value_q > ins_value);

	always_comb begin
		next_value = value_q;
		if (ctl.ins) begin
			priority if (left_gt) begin
				next_value = left_value;
			end else if (gt || ctl.at_tail) begin
				next_value = ins_value;
			end else begin
				// below the insertion point or past the tail, entry stays
				next_value = value_q;
			end
		end else if (ctl.rem && ctl.past_pos) begin
			next_value = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= next_value;
	end

	assign value = value_q;

endmodule
